[design/utf8d_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder.
package utf8d_pkg;

    localparam int FifoDepth = 4;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int CntW      = $clog2(FifoDepth + 1);

    localparam logic [2:0] TailSat = 3'd7;

    typedef struct packed {
        logic [31:0] code_point;
        logic        is_valid;
        logic        run_last;
    } result_t;

endpackage

[design/utf8_stream_decoder.sv]
// UTF-8 stream decoder: classifies bytes, folds sequences into code points.
//
// Takes one UTF-8 byte per input beat (tlast marks the final byte of the stream) and
// gives code points, each tagged valid or invalid in tuser, with tlast on the final
// result caused by its byte. Each byte is decoded in the cycle it is accepted, so while
// the queue has room a new byte can be accepted on every clock. A byte gives zero, one
// or two results: when the byte ends an open sequence and also stands for a result of
// its own, both results are written to the output queue in the same cycle and are sent
// in two output beats. The output queue holds four results. Input is accepted while at
// least two entries are free, so the downstream side can stall at any time without
// losing a result. With a steady one-result-per-byte stream and no output stall,
// throughput is one byte per cycle. Results are registered before they are sent.
module utf8_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // stream_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] code_point
    output logic        m_axis_tuser,   // is_valid
    output logic        m_axis_tlast    // run_last
);
    import utf8d_pkg::*;

    logic            seq_open_reg, seq_open_next;
    logic [31:0]     acc_code_reg, acc_code_next;
    logic [1:0]      exp_tail_reg, exp_tail_next;
    logic [2:0]      tail_seen_reg, tail_seen_next;

    result_t         fifo_reg [FifoDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg, count_next;

    logic            s_acc, m_pop;
    logic [7:0]      b;
    logic            fin, is_cont, is_ascii, lead2, lead3, lead4, is_lead;
    logic [31:0]     acc_ext;
    logic [2:0]      seen_ext;
    logic [31:0]     lead_acc;
    logic [1:0]      lead_exp;
    result_t         res0, res1;
    logic            push0, push1;
    logic [1:0]      push_n;

    assign s_axis_tready = (count_reg <= CntW'(FifoDepth - 2));
    assign m_axis_tvalid = (count_reg != '0);
    assign s_acc         = s_axis_tvalid & s_axis_tready;
    assign m_pop         = m_axis_tvalid & m_axis_tready;

    assign m_axis_tdata  = fifo_reg[rd_ptr_reg].code_point;
    assign m_axis_tuser  = fifo_reg[rd_ptr_reg].is_valid;
    assign m_axis_tlast  = fifo_reg[rd_ptr_reg].run_last;

    assign b        = s_axis_tdata;
    assign fin      = s_axis_tlast;
    assign is_cont  = (b[7:6] == 2'b10);
    assign is_ascii = ~b[7];
    assign lead4    = (b[7:3] == 5'b11110);
    assign lead3    = (b[7:4] == 4'b1110);
    assign lead2    = (b[7:5] == 3'b110);
    assign is_lead  = lead2 | lead3 | lead4;

    // Continuation bits shift in; the low six bits come from the continuation byte.
    assign acc_ext  = {acc_code_reg[25:0], b[5:0]};
    assign seen_ext = (tail_seen_reg == TailSat) ? TailSat : tail_seen_reg + 3'd1;

    always_comb
    begin
        lead_acc = {24'd0, b & 8'h1f};
        lead_exp = 2'd1;
        if (lead4)
        begin
            lead_acc = {24'd0, b & 8'h07};
            lead_exp = 2'd3;
        end
        else if (lead3)
        begin
            lead_acc = {24'd0, b & 8'h0f};
            lead_exp = 2'd2;
        end
    end

    always_comb
    begin
        res0           = '0;
        res1           = '0;
        push0          = 1'b0;
        push1          = 1'b0;
        seq_open_next  = seq_open_reg;
        acc_code_next  = acc_code_reg;
        exp_tail_next  = exp_tail_reg;
        tail_seen_next = tail_seen_reg;

        if (s_acc)
        begin
            if (seq_open_reg && is_cont)
            begin
                acc_code_next  = acc_ext;
                tail_seen_next = seen_ext;
                res0.code_point = acc_ext;
                res0.is_valid   = (seen_ext == {1'b0, exp_tail_reg});
                res0.run_last   = 1'b1;
                push0           = fin;
            end
            else
            begin
                // Close the open sequence first.
                res0.code_point = acc_code_reg;
                res0.is_valid   = (tail_seen_reg == {1'b0, exp_tail_reg});
                res0.run_last   = 1'b1;
                push0           = seq_open_reg;

                if (is_lead)
                begin
                    seq_open_next  = 1'b1;
                    acc_code_next  = lead_acc;
                    exp_tail_next  = lead_exp;
                    tail_seen_next = 3'd0;
                    res1.code_point = lead_acc;
                    res1.is_valid   = 1'b0;
                    res1.run_last   = 1'b1;
                    push1           = fin;
                end
                else
                begin
                    seq_open_next  = 1'b0;
                    acc_code_next  = '0;
                    exp_tail_next  = '0;
                    tail_seen_next = '0;
                    res1.code_point = {24'd0, b};
                    res1.is_valid   = is_ascii;
                    res1.run_last   = 1'b1;
                    push1           = 1'b1;
                end

                if (push1)
                begin
                    res0.run_last = 1'b0;
                end

                // Compact: lone second result goes into the first slot.
                if (!push0)
                begin
                    res0  = res1;
                    push0 = push1;
                    push1 = 1'b0;
                end
            end

            if (fin)
            begin
                seq_open_next  = 1'b0;
                acc_code_next  = '0;
                exp_tail_next  = '0;
                tail_seen_next = '0;
            end
        end
    end

    assign push_n     = {1'b0, push0} + {1'b0, push1};
    assign count_next = count_reg + CntW'(push_n) - CntW'(m_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_open_reg  <= 1'b0;
            acc_code_reg  <= '0;
            exp_tail_reg  <= '0;
            tail_seen_reg <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            seq_open_reg  <= seq_open_next;
            acc_code_reg  <= acc_code_next;
            exp_tail_reg  <= exp_tail_next;
            tail_seen_reg <= tail_seen_next;
            wr_ptr_reg    <= wr_ptr_reg + PtrW'(push_n);
            rd_ptr_reg    <= rd_ptr_reg + PtrW'(m_pop);
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (push1)
        begin
            fifo_reg[wr_ptr_reg + PtrW'(1)] <= res1;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(FifoDepth))
        else $error("output queue overflow");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_axis_tlast) |=> (!seq_open_reg && tail_seen_reg == 3'd0))
        else $error("sequence state not cleared at stream end");

    a_ascii_one: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && !seq_open_reg && !s_axis_tdata[7])
        |=> count_reg == $past(count_reg) + CntW'(1) - CntW'($past(m_pop)))
        else $error("ASCII byte did not push exactly one result");

    a_cont_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && seq_open_reg && s_axis_tdata[7:6] == 2'b10 && !s_axis_tlast)
        |=> count_reg == $past(count_reg) - CntW'($past(m_pop)))
        else $error("mid-sequence continuation pushed a result");
`endif

endmodule
